// File: sv/escaped_field_tokenizer_assert.svh
// assertion macros for the escaped field tokenizer checker
// no dependencies; taken in by the checker file
`ifndef ESCAPED_FIELD_TOKENIZER_ASSERT_SVH
`define ESCAPED_FIELD_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ETOK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("escaped_field_tokenizer assertion failed");

// next-cycle implication, disabled while reset is low
`define ETOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("escaped_field_tokenizer assertion failed");

`endif

// File: sv/etok_pkg.sv
// shared types, codes and character helpers of the escaped field tokenizer
// no dependencies; used by every rtl file through scoped names
package etok_pkg;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_FIELD = 3'd1,
        KIND_KEY   = 3'd2,
        KIND_LIST  = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_out;
        logic [7:0] slot;
    } t_res;

    localparam int MAX_RES = 3;

    // results caused by one character, oldest in res[0]
    typedef struct packed {
        logic [1:0]              count;
        t_res [MAX_RES-1:0]      res;
    } t_bundle;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] MAX_FIELDS_RESET = 8'd64;
    localparam logic [8:0] DELIM_NONE       = 9'h100;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    function automatic logic is_blank(input logic [8:0] c);
        is_blank = (c == 9'h020) || (c >= 9'h009 && c <= 9'h00D);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        is_delim = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
                   (c == 8'h2C) || (c == 8'h3B) || (c == CH_HASH) || (c == 8'h3A) ||
                   (c == 8'h2F) || (c == 8'h7C);
    endfunction

    function automatic t_res make_res(input t_kind k, input logic [7:0] b,
                                      input logic [7:0] s);
        t_res r;
        r.kind     = k;
        r.byte_out = b;
        r.slot     = s;
        make_res   = r;
    endfunction

endpackage

// File: sv/escaped_field_tokenizer.sv
// escaped field tokenizer top level: front end, bundle queue, back end
// depends on etok_pkg, etok_front, etok_queue, etok_back
//
// input side is a queue write port: present a character on i_ch with
// i_push; it is taken at a clock edge where o_full is low. a zero
// character ends the line. output side is a queue read port: while
// o_empty is low the oldest result sits on o_kind, o_byte_out, o_slot and
// o_last, and i_pop takes it. o_last marks the final result of a character.
// one character enters per cycle while o_full is low; the front end decodes
// it in that cycle and writes its results (zero to three) as one bundle into
// a four-deep queue. the back end hands out one result per cycle while the
// receiver pops, so a character with several results takes one pop per
// result. the first result of a character passes through the queue and the
// back end's bundle register before it shows on the outputs.
// the user must write max_fields (i_cfg_we, i_cfg_wdata) only while idle;
// the block does not enforce it. reset clears line state and the queue and
// sets max_fields to 64. when the receiver stalls the queue fills and o_full
// holds off input; characters that make no result never occupy the queue.
module escaped_field_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_ch,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic [7:0]  o_slot,
    output logic        o_last
);

    logic                 accept;
    logic                 q_push, q_pop, q_full, q_valid;
    etok_pkg::t_bundle    q_in, q_head;

    // a character is taken whenever the queue has room
    assign accept = i_push && !q_full;
    assign o_full = q_full;

    etok_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_ch        (i_ch),
        .o_q_push    (q_push),
        .o_q_bundle  (q_in)
    );

    // decouples decode from result delivery
    etok_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    etok_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_kind     (o_kind),
        .o_byte_out (o_byte_out),
        .o_slot     (o_slot),
        .o_last     (o_last)
    );

endmodule

// File: sv/etok_front.sv
// front end: line state machine that decodes one accepted character per cycle
// into a bundle of up to three results; uses etok_pkg
module etok_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [7:0]            i_ch,
    output logic                  o_q_push,
    output etok_pkg::t_bundle     o_q_bundle
);

    logic       r_afs, n_afs;
    logic       r_fopen, n_fopen;
    logic [1:0] r_quote, n_quote;
    logic       r_esc, n_esc;
    logic       r_oct, n_oct;
    logic [7:0] r_octv, n_octv;
    logic [8:0] r_ld, n_ld;
    logic [7:0] r_slot, n_slot;
    logic       r_fe, n_fe;
    logic       r_skip, n_skip;
    logic [7:0] r_maxf;

    logic [1:0]                       cnt;
    etok_pkg::t_res [etok_pkg::MAX_RES-1:0] res;
    logic                             fc;
    logic [1:0]                       code;
    logic                             ld_blank;
    logic                             is_oct;

    always_comb begin
        n_afs   = r_afs;
        n_fopen = r_fopen;
        n_quote = r_quote;
        n_esc   = r_esc;
        n_oct   = r_oct;
        n_octv  = r_octv;
        n_ld    = r_ld;
        n_slot  = r_slot;
        n_fe    = r_fe;
        n_skip  = r_skip;
        cnt     = 2'd0;
        res     = '0;
        fc      = 1'b0;
        code    = etok_pkg::QUOTE_NONE;
        ld_blank = 1'b0;
        is_oct  = (i_ch >= etok_pkg::CH_ZERO) && (i_ch <= etok_pkg::CH_SEVEN);

        if (r_skip) begin
            if (i_ch == etok_pkg::CH_NUL) begin
                n_afs = 1'b1; n_fopen = 1'b0; n_quote = etok_pkg::QUOTE_NONE;
                n_esc = 1'b0; n_oct = 1'b0; n_octv = 8'd0;
                n_ld = etok_pkg::DELIM_NONE; n_slot = 8'd0; n_fe = 1'b1; n_skip = 1'b0;
            end
        end else if (r_esc) begin
            n_esc = 1'b0;
            if (i_ch == etok_pkg::CH_NUL) begin
                // line end right after backslash closes the field
                if (n_fe && n_ld == {1'b0, etok_pkg::CH_HASH}) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_FIELD, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0,
                                                  n_slot + 8'd1);
                    cnt = cnt + 2'd1;
                end
                n_afs = 1'b1; n_fopen = 1'b0; n_quote = etok_pkg::QUOTE_NONE;
                n_oct = 1'b0; n_octv = 8'd0;
                n_ld = etok_pkg::DELIM_NONE; n_slot = 8'd0; n_fe = 1'b1; n_skip = 1'b0;
            end else if (is_oct) begin
                n_oct  = 1'b1;
                n_octv = i_ch - etok_pkg::CH_ZERO;
            end else begin
                case (i_ch)
                    etok_pkg::CH_LOW_R: res[cnt] =
                        etok_pkg::make_res(etok_pkg::KIND_DATA, 8'd13, 8'd0);
                    etok_pkg::CH_LOW_N: res[cnt] =
                        etok_pkg::make_res(etok_pkg::KIND_DATA, 8'd10, 8'd0);
                    etok_pkg::CH_LOW_B: res[cnt] =
                        etok_pkg::make_res(etok_pkg::KIND_DATA, 8'd8, 8'd0);
                    etok_pkg::CH_LOW_F: res[cnt] =
                        etok_pkg::make_res(etok_pkg::KIND_DATA, 8'd12, 8'd0);
                    default: res[cnt] =
                        etok_pkg::make_res(etok_pkg::KIND_DATA, i_ch, 8'd0);
                endcase
                cnt  = cnt + 2'd1;
                n_fe = 1'b0;
            end
        end else if (r_oct && is_oct) begin
            n_octv = {r_octv[4:0], 3'b000} | (i_ch - etok_pkg::CH_ZERO);
        end else begin
            if (r_oct) begin
                res[cnt] = etok_pkg::make_res(etok_pkg::KIND_DATA, r_octv, 8'd0);
                cnt    = cnt + 2'd1;
                n_fe   = 1'b0;
                n_oct  = 1'b0;
                n_octv = 8'd0;
            end
            if (n_afs && !n_fopen) begin
                if (i_ch == etok_pkg::CH_NUL) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                    n_afs = 1'b1; n_fopen = 1'b0; n_quote = etok_pkg::QUOTE_NONE;
                    n_esc = 1'b0; n_oct = 1'b0; n_octv = 8'd0;
                    n_ld = etok_pkg::DELIM_NONE; n_slot = 8'd0; n_fe = 1'b1;
                    n_skip = 1'b0;
                end else if ({1'b0, n_slot} + 9'd2 >= {1'b0, r_maxf}) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_ERROR, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                    n_skip = 1'b1;
                end else begin
                    n_fopen = 1'b1;
                    n_quote = etok_pkg::QUOTE_NONE;
                    n_fe    = 1'b1;
                    fc      = !etok_pkg::is_blank({1'b0, i_ch});
                end
            end else if (i_ch == etok_pkg::CH_NUL) begin
                if (n_fe && n_ld == {1'b0, etok_pkg::CH_HASH}) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_FIELD, 8'd0, n_slot);
                    cnt = cnt + 2'd1;
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0,
                                                  n_slot + 8'd1);
                    cnt = cnt + 2'd1;
                end
                n_afs = 1'b1; n_fopen = 1'b0; n_quote = etok_pkg::QUOTE_NONE;
                n_esc = 1'b0; n_oct = 1'b0; n_octv = 8'd0;
                n_ld = etok_pkg::DELIM_NONE; n_slot = 8'd0; n_fe = 1'b1; n_skip = 1'b0;
            end else begin
                fc = !(n_afs && etok_pkg::is_blank({1'b0, i_ch}));
            end
        end

        // ordinary character inside a field
        if (fc) begin
            n_afs    = 1'b0;
            ld_blank = etok_pkg::is_blank(n_ld);
            if (i_ch == etok_pkg::CH_DQUOTE || i_ch == etok_pkg::CH_SQUOTE) begin
                code = (i_ch == etok_pkg::CH_DQUOTE) ? etok_pkg::QUOTE_DOUBLE
                                                     : etok_pkg::QUOTE_SINGLE;
                if (n_quote == code) begin
                    n_quote = etok_pkg::QUOTE_NONE;
                end else if (n_quote != etok_pkg::QUOTE_NONE) begin
                    if (cnt != 2'd3) begin
                        res[cnt] = etok_pkg::make_res(etok_pkg::KIND_DATA, i_ch, 8'd0);
                        cnt = cnt + 2'd1;
                    end
                    n_fe = 1'b0;
                end else begin
                    n_quote = code;
                end
                n_ld = etok_pkg::DELIM_NONE;
            end else if (i_ch == etok_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
                n_ld  = etok_pkg::DELIM_NONE;
            end else if (i_ch == etok_pkg::CH_EQUALS && n_quote == etok_pkg::QUOTE_NONE) begin
                if (cnt != 2'd3) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_KEY, 8'd0, n_slot + 8'd1);
                    cnt = cnt + 2'd1;
                end
                n_slot  = n_slot + 8'd2;
                n_ld    = {1'b0, etok_pkg::CH_EQUALS};
                n_afs   = 1'b1;
                n_fopen = 1'b0;
            end else if (etok_pkg::is_delim(i_ch) && n_quote == etok_pkg::QUOTE_NONE) begin
                n_ld = {1'b0, i_ch};
                if (ld_blank && i_ch != etok_pkg::CH_HASH) begin
                    // delimiter other than hash after whitespace: no empty field
                    n_afs   = 1'b1;
                    n_fopen = 1'b0;
                end else if (n_fe && i_ch == etok_pkg::CH_HASH) begin
                    if (cnt != 2'd3) begin
                        res[cnt] = etok_pkg::make_res(etok_pkg::KIND_LIST, 8'd0, n_slot);
                        cnt = cnt + 2'd1;
                    end
                    n_skip = 1'b1;
                end else begin
                    if (cnt != 2'd3) begin
                        res[cnt] = etok_pkg::make_res(etok_pkg::KIND_FIELD, 8'd0, n_slot);
                        cnt = cnt + 2'd1;
                    end
                    n_slot  = n_slot + 8'd1;
                    n_afs   = 1'b1;
                    n_fopen = 1'b0;
                end
            end else begin
                if (cnt != 2'd3) begin
                    res[cnt] = etok_pkg::make_res(etok_pkg::KIND_DATA, i_ch, 8'd0);
                    cnt = cnt + 2'd1;
                end
                n_fe = 1'b0;
                n_ld = etok_pkg::DELIM_NONE;
            end
        end
    end

    assign o_q_push         = i_accept && (cnt != 2'd0);
    assign o_q_bundle.count = cnt;
    assign o_q_bundle.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_afs   <= 1'b1;
            r_fopen <= 1'b0;
            r_quote <= etok_pkg::QUOTE_NONE;
            r_esc   <= 1'b0;
            r_oct   <= 1'b0;
            r_octv  <= 8'd0;
            r_ld    <= etok_pkg::DELIM_NONE;
            r_slot  <= 8'd0;
            r_fe    <= 1'b1;
            r_skip  <= 1'b0;
            r_maxf  <= etok_pkg::MAX_FIELDS_RESET;
        end else begin
            if (i_accept) begin
                r_afs   <= n_afs;
                r_fopen <= n_fopen;
                r_quote <= n_quote;
                r_esc   <= n_esc;
                r_oct   <= n_oct;
                r_octv  <= n_octv;
                r_ld    <= n_ld;
                r_slot  <= n_slot;
                r_fe    <= n_fe;
                r_skip  <= n_skip;
            end
            if (i_cfg_we) begin
                r_maxf <= i_cfg_wdata;
            end
        end
    end

endmodule

// File: sv/etok_queue.sv
// short queue of result bundles between front and back end
// uses etok_pkg for the bundle type and depth
module etok_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  etok_pkg::t_bundle     i_bundle,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output etok_pkg::t_bundle     o_head
);

    etok_pkg::t_bundle                r_mem [etok_pkg::QUEUE_DEPTH];
    logic [etok_pkg::QPTR_W-1:0]      r_wr, r_rd;
    logic [etok_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                             do_push, do_pop;

    assign o_full  = (r_cnt == etok_pkg::QCNT_W'(etok_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// File: sv/etok_back.sv
// back end: holds one bundle and hands its results out one per pop
// uses etok_pkg for the bundle type
module etok_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  etok_pkg::t_bundle     i_q_head,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_byte_out,
    output logic [7:0]            o_slot,
    output logic                  o_last
);

    logic                 r_valid;
    etok_pkg::t_bundle    r_bundle;
    logic [1:0]           r_idx;
    logic                 is_last, done;
    etok_pkg::t_res       cur;

    assign cur     = r_bundle.res[r_idx];
    assign is_last = (r_idx == r_bundle.count - 2'd1);
    assign done    = r_valid && i_pop && is_last;
    assign o_q_pop = i_q_valid && (!r_valid || done);

    assign o_empty    = !r_valid;
    assign o_kind     = cur.kind;
    assign o_byte_out = cur.byte_out;
    assign o_slot     = cur.slot;
    assign o_last     = is_last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bundle <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// File: sv/etok_checker.sv
// port-level checker for the escaped field tokenizer, bound to the top
// depends on etok_pkg and escaped_field_tokenizer_assert.svh
`include "escaped_field_tokenizer_assert.svh"

module etok_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pop,
    input logic        o_empty,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_byte_out,
    input logic [7:0]  o_slot,
    input logic        o_last
);

    logic        res_valid;
    logic        is_data;
    logic        is_end;
    logic [19:0] res_bits;

    assign res_valid = !o_empty;
    assign is_data   = (o_kind == etok_pkg::KIND_DATA);
    assign is_end    = (o_kind == etok_pkg::KIND_LIST) || (o_kind == etok_pkg::KIND_ERROR);
    assign res_bits  = {o_kind, o_byte_out, o_slot, o_last};

    `ETOK_ASSERT_NOW(a_data_slot_zero, i_clk, i_rst_n, res_valid && is_data, o_slot == 8'd0)
    `ETOK_ASSERT_NOW(a_marker_byte_zero, i_clk, i_rst_n, res_valid && !is_data, o_byte_out == 8'd0)
    `ETOK_ASSERT_NOW(a_list_end_is_last, i_clk, i_rst_n, res_valid && is_end, o_last)
    `ETOK_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, res_valid && !i_pop, res_valid && $stable(res_bits))

endmodule

bind escaped_field_tokenizer etok_checker u_etok_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_pop      (i_pop),
    .o_empty    (o_empty),
    .o_kind     (o_kind),
    .o_byte_out (o_byte_out),
    .o_slot     (o_slot),
    .o_last     (o_last)
);
